### sv/spi_mbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spi_mbe_pkg;

  // Bus access carried with each tick
  typedef enum logic [1:0] {
    CmdTick       = 2'd0,
    CmdWrite      = 2'd1,
    CmdReadData   = 2'd2,
    CmdReadStatus = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [CfgAddrW-1:0] {
    CfgEnable    = 3'd0,
    CfgClockPol  = 3'd1,
    CfgClockPha  = 3'd2,
    CfgBaudExp   = 3'd3,
    CfgLsbFirst  = 3'd4
  } cfg_reg_e;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned BaudExpW = 3;
  // Half-period counter; limit is 2^baud_exp, up to 128
  localparam int unsigned HalfCntW = 7;

  // Status word bit positions
  localparam int unsigned StatusTxeBit  = 0;
  localparam int unsigned StatusRxneBit = 1;
  localparam int unsigned StatusBusyBit = 2;

  typedef struct packed {
    logic                enable;
    logic                clock_polarity;
    logic                clock_phase;
    logic [BaudExpW-1:0] baud_exp;
    logic                lsb_first;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] read_value;
    logic             sck;
    logic             mosi;
    logic             tx_empty;
    logic             rx_not_empty;
    logic             busy;
  } result_t;

endpackage

`default_nettype wire

### sv/spi_mbe_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Bus access, load and bit engine for one tick. State advances on step_i;
// res_o shows the result word of the tick being stepped.
module spi_mbe_engine #(
  parameter int unsigned DATA_BITS = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic [1:0]                  command_i,
  input  wire logic [spi_mbe_pkg::ByteW-1:0] write_byte_i,
  input  wire logic                        miso_i,
  input  wire spi_mbe_pkg::cfg_t           cfg_i,
  output spi_mbe_pkg::result_t             res_o
);

  localparam int unsigned BitsW = $clog2(DATA_BITS);
  localparam int unsigned CntW  = spi_mbe_pkg::HalfCntW + 1;

  logic [DATA_BITS-1:0] tx_hold_q, tx_hold_d;
  logic                 tx_full_q, tx_full_d;
  logic [DATA_BITS-1:0] shifter_q, shifter_d;
  logic [BitsW-1:0]     bits_q, bits_d;
  logic [spi_mbe_pkg::HalfCntW-1:0] half_cnt_q, half_cnt_d;
  logic                 second_half_q, second_half_d;
  logic [DATA_BITS-1:0] rx_hold_q, rx_hold_d;
  logic                 rx_full_q, rx_full_d;
  logic                 sck_q, sck_d;
  logic                 shifting_q, shifting_d;
  logic                 mosi_q, mosi_d;

  logic [spi_mbe_pkg::ByteW-1:0] read_value;
  logic [DATA_BITS-1:0] shift_next;
  logic [DATA_BITS-1:0] done_word;
  logic [CntW-1:0]      cnt_inc;
  logic [CntW-1:0]      cnt_limit;
  logic                 out_bit_cur;
  logic                 out_bit_load;

  // Bit on the line for the current shifter and for a word just loaded
  assign out_bit_cur  = cfg_i.lsb_first ? shifter_q[0] : shifter_q[DATA_BITS-1];

  always_comb begin
    out_bit_load = cfg_i.lsb_first ? tx_hold_d[0] : tx_hold_d[DATA_BITS-1];
  end

  assign shift_next = cfg_i.lsb_first ? {miso_i, shifter_q[DATA_BITS-1:1]}
                                      : {shifter_q[DATA_BITS-2:0], miso_i};

  assign cnt_inc   = {1'b0, half_cnt_q} + CntW'(1);
  assign cnt_limit = CntW'(1) << cfg_i.baud_exp;
  assign done_word = cfg_i.clock_phase ? shift_next : shifter_q;

  always_comb begin
    tx_hold_d     = tx_hold_q;
    tx_full_d     = tx_full_q;
    shifter_d     = shifter_q;
    bits_d        = bits_q;
    half_cnt_d    = half_cnt_q;
    second_half_d = second_half_q;
    rx_hold_d     = rx_hold_q;
    rx_full_d     = rx_full_q;
    sck_d         = sck_q;
    shifting_d    = shifting_q;
    mosi_d        = mosi_q;
    read_value    = '0;

    // Bus access sees the state from before this tick
    case (spi_mbe_pkg::cmd_e'(command_i))
      spi_mbe_pkg::CmdWrite: begin
        if (!tx_full_q) begin
          tx_hold_d = DATA_BITS'(write_byte_i);
          tx_full_d = 1'b1;
        end
      end
      spi_mbe_pkg::CmdReadData: begin
        read_value = rx_hold_q[spi_mbe_pkg::ByteW-1:0];
        rx_full_d  = 1'b0;
      end
      spi_mbe_pkg::CmdReadStatus: begin
        read_value[spi_mbe_pkg::StatusBusyBit] = shifting_q;
        read_value[spi_mbe_pkg::StatusRxneBit] = rx_full_q;
        read_value[spi_mbe_pkg::StatusTxeBit]  = ~tx_full_q;
      end
      default: begin
      end
    endcase

    if (!shifting_q) begin
      sck_d = cfg_i.clock_polarity;
      if (cfg_i.enable && tx_full_d) begin
        shifter_d     = tx_hold_d;
        tx_full_d     = 1'b0;
        shifting_d    = 1'b1;
        bits_d        = '0;
        half_cnt_d    = '0;
        second_half_d = 1'b0;
        if (!cfg_i.clock_phase) begin
          mosi_d = out_bit_load;
        end
      end
    end else begin
      half_cnt_d = cnt_inc[spi_mbe_pkg::HalfCntW-1:0];
      if (cnt_inc >= cnt_limit) begin
        half_cnt_d = '0;
        sck_d      = ~sck_q;
        if (!second_half_q) begin
          // leading edge: sample (phase 0) or drive (phase 1)
          second_half_d = 1'b1;
          if (!cfg_i.clock_phase) begin
            shifter_d = shift_next;
          end else begin
            mosi_d = out_bit_cur;
          end
        end else begin
          // trailing edge: sample (phase 1) or drive the next bit (phase 0), count the bit
          second_half_d = 1'b0;
          shifter_d     = done_word;
          bits_d        = bits_q + BitsW'(1);
          if (bits_q == BitsW'(DATA_BITS - 1)) begin
            rx_hold_d  = done_word;
            rx_full_d  = 1'b1;
            shifting_d = 1'b0;
            bits_d     = '0;
            sck_d      = cfg_i.clock_polarity;
          end else if (!cfg_i.clock_phase) begin
            mosi_d = out_bit_cur;
          end
        end
      end
    end
  end

  always_comb begin
    res_o.read_value   = read_value;
    res_o.sck          = sck_d;
    res_o.mosi         = mosi_d;
    res_o.tx_empty     = ~tx_full_d;
    res_o.rx_not_empty = rx_full_d;
    res_o.busy         = shifting_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_hold_q     <= '0;
      tx_full_q     <= 1'b0;
      shifter_q     <= '0;
      bits_q        <= '0;
      half_cnt_q    <= '0;
      second_half_q <= 1'b0;
      rx_hold_q     <= '0;
      rx_full_q     <= 1'b0;
      sck_q         <= 1'b0;
      shifting_q    <= 1'b0;
      mosi_q        <= 1'b0;
    end else if (step_i) begin
      tx_hold_q     <= tx_hold_d;
      tx_full_q     <= tx_full_d;
      shifter_q     <= shifter_d;
      bits_q        <= bits_d;
      half_cnt_q    <= half_cnt_d;
      second_half_q <= second_half_d;
      rx_hold_q     <= rx_hold_d;
      rx_full_q     <= rx_full_d;
      sck_q         <= sck_d;
      shifting_q    <= shifting_d;
      mosi_q        <= mosi_d;
    end
  end

  // idle engine always rests at the start of a bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !shifting_q |-> (bits_q == '0) && !second_half_q)
    else $error("idle engine left mid-word");

  // a word only completes on a trailing edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && shifting_q && !shifting_d |-> second_half_q)
    else $error("transfer ended outside a trailing edge");

endmodule

`default_nettype wire

### sv/spi_master_byte_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Full-duplex SPI master, modes 0 to 3. Each input word is one peripheral
// clock tick plus an optional bus access (write data, read data, read
// status); each tick returns one result word with the read value and the
// SCK, MOSI and flag levels after that tick. The bit engine updates its
// state on acceptance and the result lands in one output register, so it
// appears the cycle after acceptance and a new tick is taken every cycle
// for as long as the output side takes results. The only stall comes from
// that output register when a result is held back. SCK toggles every
// 2^baud_exp ticks. Configuration is written through its own port (always
// ready) and should only change while no result is pending.
module spi_master_byte_engine #(
  parameter int unsigned DATA_BITS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [spi_mbe_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [spi_mbe_pkg::CfgDataW-1:0]  cfg_data_i,
  // tick words
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic [1:0]                        command_i,
  input  wire logic [spi_mbe_pkg::ByteW-1:0]     write_byte_i,
  input  wire logic                              miso_i,
  // result words
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [spi_mbe_pkg::ByteW-1:0]     read_value_o,
  output      logic                              sck_o,
  output      logic                              mosi_o,
  output      logic                              tx_empty_o,
  output      logic                              rx_not_empty_o,
  output      logic                              busy_res_o
);

  spi_mbe_pkg::cfg_t    cfg_q, cfg_d;
  spi_mbe_pkg::result_t res_next;
  spi_mbe_pkg::result_t res_q;
  logic                 out_valid_q, out_valid_d;
  logic                 in_fire;
  logic                 cfg_fire;

  // config port never stalls
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_fire) begin
      case (spi_mbe_pkg::cfg_reg_e'(cfg_addr_i))
        spi_mbe_pkg::CfgEnable:   cfg_d.enable         = cfg_data_i[0];
        spi_mbe_pkg::CfgClockPol: cfg_d.clock_polarity = cfg_data_i[0];
        spi_mbe_pkg::CfgClockPha: cfg_d.clock_phase    = cfg_data_i[0];
        spi_mbe_pkg::CfgBaudExp:
          cfg_d.baud_exp = cfg_data_i[spi_mbe_pkg::BaudExpW-1:0];
        spi_mbe_pkg::CfgLsbFirst: cfg_d.lsb_first      = cfg_data_i[0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // Output register frees up when its word is taken in the same cycle
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  spi_mbe_engine #(
    .DATA_BITS (DATA_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_fire),
    .command_i    (command_i),
    .write_byte_i (write_byte_i),
    .miso_i       (miso_i),
    .cfg_i        (cfg_q),
    .res_o        (res_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = res_q.read_value;
  assign sck_o          = res_q.sck;
  assign mosi_o         = res_q.mosi;
  assign tx_empty_o     = res_q.tx_empty;
  assign rx_not_empty_o = res_q.rx_not_empty;
  assign busy_res_o     = res_q.busy;

  // every accepted tick leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted tick produced no result");

  // input only stalls behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q && !out_ready_i)
    else $error("input stalled with free output register");

  // a result that is taken without a new tick empties the register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ready_i && !in_fire |=> !out_valid_q)
    else $error("result repeated after delivery");

endmodule

`default_nettype wire
